// File: hdl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants of the MIPS subset executor: opcode and
// function codes, the sequencer state type and the structs between modules.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Program counter loaded at reset.
  localparam logic [31:0] RESET_PC = 32'h0000_3000;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // Function codes of the special opcode.
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // REGIMM branch selectors in the rt field.
  localparam logic [4:0] RI_BLTZ = 5'd0;
  localparam logic [4:0] RI_BGEZ = 5'd1;

  // Link register of JAL.
  localparam logic [4:0] LINK_REG = 5'd31;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_DEC  = 7'b0000100,
    ST_MD   = 7'b0001000,
    ST_ADR  = 7'b0010000,
    ST_EXE  = 7'b0100000,
    ST_HOLD = 7'b1000000
  } state_t;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic        is_signed;
    logic [31:0] a;
    logic [31:0] b;
  } mdu_req_t;

  // Status and result of the shared unit.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } mdu_res_t;

  // Decoded and executed view of one instruction.
  typedef struct packed {
    logic        ok;
    logic        wr;
    logic [4:0]  ridx;
    logic [31:0] rval;
    logic        mw;
    logic [31:0] mval;
    logic        xfer;
    logic [31:0] tgt;
    logic [31:0] seq;
    logic [31:0] nhi;
    logic [31:0] nlo;
    logic        is_mem;
    logic        is_md;
    logic        md_div;
    logic        md_signed;
    logic [31:0] ea;
  } exec_res_t;

endpackage

// File: hdl/mips_subset_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_core
// Multiply, divide, and loads and stores when DATA_WORDS is not a power of
// two wait for the 32 steps of the shared unit before the result is
// registered. The next word is taken only once the result is produced: the
// core does not accept a new word while one is still in progress.
// After reset the register file and data memory are cleared, during which
// no input word is accepted.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor_core #(
  parameter int DATA_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_start_pc,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_exec_pc,
  output logic        out_reg_we,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_mem_we,
  output logic [13:0] out_mem_byte_addr,
  output logic [31:0] out_mem_value,
  output logic [31:0] out_next_pc,
  output logic        out_illegal
);

  localparam int  AW    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int  CLR_N = (DATA_WORDS > 32) ? DATA_WORDS : 32;
  localparam int  CW    = $clog2(CLR_N);
  localparam bit  POW2  = ((DATA_WORDS & (DATA_WORDS - 1)) == 0);

  mse_pkg::state_t   state_r, state_nxt;
  mse_pkg::exec_res_t ex;
  mse_pkg::mdu_req_t md_req;
  mse_pkg::mdu_res_t md_res;

  logic [CW-1:0] clr_r;
  logic [31:0]   gpr [32];
  logic [31:0]   dmem [DATA_WORDS];
  logic [31:0]   instr_r, vs_r, vt_r, mword_r, hi_r, lo_r;
  logic [31:0]   fetch_pc_r, slot_target_r;
  logic          slot_pending_r;
  logic [AW-1:0] widx_r, rd_addr;
  logic          rd_en, commit, out_free, accept;
  logic [31:0]   next_pc;
  logic [AW+1:0] byte_addr;

  assign accept    = in_valid && (state_r == mse_pkg::ST_IDLE);
  assign in_stall  = (state_r != mse_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign commit    = (state_r == mse_pkg::ST_EXE) && out_free;

  // Instruction execute logic.
  mse_exec u_exec (
    .instr (instr_r),
    .pc    (fetch_pc_r),
    .vs    (vs_r),
    .vt    (vt_r),
    .mword (mword_r),
    .hi    (hi_r),
    .lo    (lo_r),
    .md_hi (md_res.hi),
    .md_lo (md_res.lo),
    .res   (ex)
  );

  // Requests to the shared unit: multiply/divide, or word index reduction.
  always_comb begin
    md_req           = '0;
    md_req.a         = vs_r;
    md_req.b         = vt_r;
    md_req.is_div    = ex.md_div;
    md_req.is_signed = ex.md_signed;
    if (state_r == mse_pkg::ST_DEC && ex.ok) begin
      if (ex.is_md) begin
        md_req.start = 1'b1;
      end else if (ex.is_mem && !POW2) begin
        md_req.start     = 1'b1;
        md_req.is_div    = 1'b1;
        md_req.is_signed = 1'b0;
        md_req.a         = {2'b00, ex.ea[31:2]};
        md_req.b         = 32'(DATA_WORDS);
      end
    end
  end

  mse_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .res   (md_res)
  );

  // Data memory read address.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ex.ea[AW+1:2];
    if (state_r == mse_pkg::ST_DEC && ex.ok && ex.is_mem && POW2) begin
      rd_en = 1'b1;
    end else if (state_r == mse_pkg::ST_ADR && md_res.done) begin
      rd_en   = 1'b1;
      rd_addr = md_res.hi[AW-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mse_pkg::ST_CLR: begin
        if (clr_r == CW'(CLR_N - 1)) state_nxt = mse_pkg::ST_IDLE;
      end
      mse_pkg::ST_IDLE: begin
        if (accept) state_nxt = mse_pkg::ST_DEC;
      end
      mse_pkg::ST_DEC: begin
        if (ex.ok && ex.is_md) begin
          state_nxt = mse_pkg::ST_MD;
        end else if (ex.ok && ex.is_mem && !POW2) begin
          state_nxt = mse_pkg::ST_ADR;
        end else begin
          state_nxt = mse_pkg::ST_EXE;
        end
      end
      mse_pkg::ST_MD: begin
        if (md_res.done) state_nxt = mse_pkg::ST_EXE;
      end
      mse_pkg::ST_ADR: begin
        if (md_res.done) state_nxt = mse_pkg::ST_EXE;
      end
      mse_pkg::ST_EXE: begin
        if (commit) state_nxt = mse_pkg::ST_IDLE;
      end
      default: state_nxt = mse_pkg::ST_IDLE;
    endcase
  end

  // Next fetch address after a committed instruction.
  always_comb begin
    if (!ex.ok) begin
      next_pc = fetch_pc_r;
    end else if (slot_pending_r) begin
      next_pc = slot_target_r;
    end else begin
      next_pc = ex.seq;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mse_pkg::ST_CLR;
      clr_r          <= '0;
      fetch_pc_r     <= mse_pkg::RESET_PC;
      slot_pending_r <= 1'b0;
      slot_target_r  <= 32'd0;
      hi_r           <= 32'd0;
      lo_r           <= 32'd0;
      out_valid      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mse_pkg::ST_CLR) begin
        clr_r <= clr_r + CW'(1);
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
        if (ex.ok) begin
          hi_r       <= ex.nhi;
          lo_r       <= ex.nlo;
          fetch_pc_r <= next_pc;
          if (slot_pending_r) begin
            slot_pending_r <= 1'b0;
          end else if (ex.xfer) begin
            slot_pending_r <= 1'b1;
            slot_target_r  <= ex.tgt;
          end
        end
      end
      // A start address write restarts fetching there.
      if (cfg_valid && cfg_ready) begin
        fetch_pc_r     <= cfg_start_pc;
        slot_pending_r <= 1'b0;
      end
    end
  end

  // Register file: two registered reads on acceptance, one write.
  always_ff @(posedge clk) begin
    if (accept) begin
      instr_r <= in_instr_word;
      vs_r    <= gpr[in_instr_word[25:21]];
      vt_r    <= gpr[in_instr_word[20:16]];
    end
    if (state_r == mse_pkg::ST_CLR) begin
      if ({1'b0, clr_r} < (CW + 1)'(32)) gpr[clr_r[4:0]] <= 32'd0;
    end else if (commit && ex.ok && ex.wr) begin
      gpr[ex.ridx] <= ex.rval;
    end
  end

  // Data memory: one registered read, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mword_r <= dmem[rd_addr];
      widx_r  <= rd_addr;
    end
    if (state_r == mse_pkg::ST_CLR) begin
      if ({1'b0, clr_r} < (CW + 1)'(DATA_WORDS)) dmem[clr_r[AW-1:0]] <= 32'd0;
    end else if (commit && ex.ok && ex.mw) begin
      dmem[widx_r] <= ex.mval;
    end
  end

  assign byte_addr = {widx_r, 2'b00};

  // Result word register.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_exec_pc       <= fetch_pc_r;
      out_next_pc       <= next_pc;
      out_illegal       <= !ex.ok;
      out_reg_we        <= ex.ok && ex.wr;
      out_reg_index     <= ex.ok ? ex.ridx : 5'd0;
      out_reg_value     <= ex.ok ? ex.rval : 32'd0;
      out_mem_we        <= ex.ok && ex.mw;
      out_mem_byte_addr <= (ex.ok && ex.mw) ? 14'(byte_addr) : 14'd0;
      out_mem_value     <= (ex.ok && ex.mw) ? ex.mval : 32'd0;
    end
  end

endmodule

// File: hdl/mse_mdu.sv
// ----------------------------------------------------------------------------
// mse_mdu
// Shared iterative multiply/divide unit: one add or subtract step per cycle
// on magnitudes for 32 steps, then a sign correction step.
// ----------------------------------------------------------------------------
module mse_mdu (
  input  logic              clk,
  input  logic              rst_n,
  input  mse_pkg::mdu_req_t req,
  output mse_pkg::mdu_res_t res
);

  logic [63:0] p_r, p_nxt;
  logic [31:0] b_r;
  logic [4:0]  cnt_r;
  logic        busy_r, fix_r, done_r, div_r, neg_lo_r, neg_hi_r;
  logic [31:0] mag_a, mag_b;
  logic [33:0] left, opnd, sum;
  logic        cin;
  logic [63:0] prod_neg;

  // Magnitudes of the operands at start.
  always_comb begin
    mag_a = (req.is_signed && req.a[31]) ? (~req.a + 32'd1) : req.a;
    mag_b = (req.is_signed && req.b[31]) ? (~req.b + 32'd1) : req.b;
  end

  // The one adder: add of the multiplicand, or trial subtract of the divisor.
  always_comb begin
    if (div_r) begin
      left = {1'b0, p_r[63:32], p_r[31]};
      opnd = ~{2'b00, b_r};
      cin  = 1'b1;
    end else begin
      left = {2'b00, p_r[63:32]};
      opnd = p_r[0] ? {2'b00, b_r} : 34'd0;
      cin  = 1'b0;
    end
    sum = left + opnd + {33'd0, cin};
    if (div_r) begin
      if (!sum[33]) begin
        p_nxt = {sum[31:0], p_r[30:0], 1'b1};
      end else begin
        p_nxt = {p_r[62:32], p_r[31], p_r[30:0], 1'b0};
      end
    end else begin
      p_nxt = {sum[32:0], p_r[31:1]};
    end
    prod_neg = ~p_r + 64'd1;
  end

  // Sequencing of the steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        fix_r  <= 1'b0;
        cnt_r  <= 5'd0;
      end else if (busy_r && !fix_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          fix_r <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      p_r      <= {32'd0, mag_a};
      b_r      <= mag_b;
      div_r    <= req.is_div;
      neg_lo_r <= req.is_signed && (req.a[31] ^ req.b[31]);
      neg_hi_r <= req.is_signed && req.a[31];
    end else if (busy_r && !fix_r) begin
      p_r <= p_nxt;
    end else if (fix_r) begin
      if (div_r) begin
        p_r[31:0]  <= neg_lo_r ? prod_neg[31:0] : p_r[31:0];
        p_r[63:32] <= neg_hi_r ? (~p_r[63:32] + 32'd1) : p_r[63:32];
      end else if (neg_lo_r) begin
        p_r <= prod_neg;
      end
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.hi   = p_r[63:32];
  assign res.lo   = p_r[31:0];

endmodule

// File: hdl/mse_exec.sv
// ----------------------------------------------------------------------------
// mse_exec
// Decode and execute of one instruction: ALU, shifts, branch and jump
// targets, load lane extraction and store merge, HI/LO updates.
// ----------------------------------------------------------------------------
module mse_exec (
  input  logic [31:0]        instr,
  input  logic [31:0]        pc,
  input  logic [31:0]        vs,
  input  logic [31:0]        vt,
  input  logic [31:0]        mword,
  input  logic [31:0]        hi,
  input  logic [31:0]        lo,
  input  logic [31:0]        md_hi,
  input  logic [31:0]        md_lo,
  output mse_pkg::exec_res_t res
);

  logic [5:0]  op, fn;
  logic [4:0]  ti, di, shamt;
  logic [31:0] imm, simm, seq, br, jt, ea, lane;
  logic [4:0]  off;
  mse_pkg::exec_res_t r;

  // Field extraction and address arithmetic.
  always_comb begin
    op    = instr[31:26];
    fn    = instr[5:0];
    ti    = instr[20:16];
    di    = instr[15:11];
    shamt = instr[10:6];
    imm   = {16'd0, instr[15:0]};
    simm  = {{16{instr[15]}}, instr[15:0]};
    seq   = pc + 32'd4;
    br    = seq + {simm[29:0], 2'b00};
    jt    = {seq[31:28], instr[25:0], 2'b00};
    ea    = vs + simm;
    off   = {ea[1:0], 3'b000};
    lane  = mword >> off;
  end

  // Execution.
  always_comb begin
    r           = '0;
    r.ok        = 1'b1;
    r.seq       = seq;
    r.ea        = ea;
    r.nhi       = hi;
    r.nlo       = lo;
    if (op == mse_pkg::OP_SPECIAL) begin
      r.wr   = 1'b1;
      r.ridx = di;
      case (fn)
        mse_pkg::FN_ADD, mse_pkg::FN_ADDU: r.rval = vs + vt;
        mse_pkg::FN_SUB, mse_pkg::FN_SUBU: r.rval = vs - vt;
        mse_pkg::FN_AND:  r.rval = vs & vt;
        mse_pkg::FN_OR:   r.rval = vs | vt;
        mse_pkg::FN_XOR:  r.rval = vs ^ vt;
        mse_pkg::FN_NOR:  r.rval = ~(vs | vt);
        mse_pkg::FN_SLT:  r.rval = {31'd0, $signed(vs) < $signed(vt)};
        mse_pkg::FN_SLTU: r.rval = {31'd0, vs < vt};
        mse_pkg::FN_SLLV: r.rval = vt << vs[4:0];
        mse_pkg::FN_SRLV: r.rval = vt >> vs[4:0];
        mse_pkg::FN_SRAV: r.rval = 32'($signed(vt) >>> vs[4:0]);
        mse_pkg::FN_SLL:  r.rval = vt << shamt;
        mse_pkg::FN_SRL:  r.rval = vt >> shamt;
        mse_pkg::FN_SRA:  r.rval = 32'($signed(vt) >>> shamt);
        mse_pkg::FN_JR: begin
          r.wr   = 1'b0;
          r.xfer = 1'b1;
          r.tgt  = vs;
        end
        mse_pkg::FN_JALR: begin
          r.rval = pc + 32'd8;
          r.xfer = 1'b1;
          r.tgt  = vs;
        end
        mse_pkg::FN_MFHI: r.rval = hi;
        mse_pkg::FN_MFLO: r.rval = lo;
        mse_pkg::FN_MTHI: begin
          r.wr  = 1'b0;
          r.nhi = vs;
        end
        mse_pkg::FN_MTLO: begin
          r.wr  = 1'b0;
          r.nlo = vs;
        end
        mse_pkg::FN_MULT, mse_pkg::FN_MULTU: begin
          r.wr        = 1'b0;
          r.is_md     = 1'b1;
          r.md_signed = (fn == mse_pkg::FN_MULT);
          r.nhi       = md_hi;
          r.nlo       = md_lo;
        end
        mse_pkg::FN_DIV, mse_pkg::FN_DIVU: begin
          r.wr        = 1'b0;
          r.is_md     = 1'b1;
          r.md_div    = 1'b1;
          r.md_signed = (fn == mse_pkg::FN_DIV);
          // A zero divisor leaves HI and LO as they were.
          if (vt != 32'd0) begin
            r.nhi = md_hi;
            r.nlo = md_lo;
          end
        end
        default: r.ok = 1'b0;
      endcase
    end else begin
      r.ridx = ti;
      case (op)
        mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
          r.wr = 1'b1; r.rval = vs + simm;
        end
        mse_pkg::OP_ANDI: begin r.wr = 1'b1; r.rval = vs & imm; end
        mse_pkg::OP_ORI:  begin r.wr = 1'b1; r.rval = vs | imm; end
        mse_pkg::OP_XORI: begin r.wr = 1'b1; r.rval = vs ^ imm; end
        mse_pkg::OP_LUI:  begin r.wr = 1'b1; r.rval = {instr[15:0], 16'd0}; end
        mse_pkg::OP_SLTI: begin
          r.wr = 1'b1; r.rval = {31'd0, $signed(vs) < $signed(simm)};
        end
        mse_pkg::OP_SLTIU: begin r.wr = 1'b1; r.rval = {31'd0, vs < simm}; end
        mse_pkg::OP_BEQ:  begin r.xfer = (vs == vt); r.tgt = br; end
        mse_pkg::OP_BNE:  begin r.xfer = (vs != vt); r.tgt = br; end
        mse_pkg::OP_BGTZ: begin r.xfer = !vs[31] && (vs != 32'd0); r.tgt = br; end
        mse_pkg::OP_BLEZ: begin r.xfer = vs[31] || (vs == 32'd0); r.tgt = br; end
        mse_pkg::OP_REGIMM: begin
          r.tgt = br;
          if (ti == mse_pkg::RI_BGEZ) begin
            r.xfer = !vs[31];
          end else if (ti == mse_pkg::RI_BLTZ) begin
            r.xfer = vs[31];
          end else begin
            r.ok = 1'b0;
          end
        end
        mse_pkg::OP_J: begin r.xfer = 1'b1; r.tgt = jt; end
        mse_pkg::OP_JAL: begin
          r.wr   = 1'b1;
          r.ridx = mse_pkg::LINK_REG;
          r.rval = pc + 32'd8;
          r.xfer = 1'b1;
          r.tgt  = jt;
        end
        mse_pkg::OP_LB: begin
          r.wr = 1'b1; r.is_mem = 1'b1; r.rval = {{24{lane[7]}}, lane[7:0]};
        end
        mse_pkg::OP_LBU: begin
          r.wr = 1'b1; r.is_mem = 1'b1; r.rval = {24'd0, lane[7:0]};
        end
        mse_pkg::OP_LH: begin
          r.wr = 1'b1; r.is_mem = 1'b1; r.rval = {{16{lane[15]}}, lane[15:0]};
        end
        mse_pkg::OP_LHU: begin
          r.wr = 1'b1; r.is_mem = 1'b1; r.rval = {16'd0, lane[15:0]};
        end
        mse_pkg::OP_LW: begin
          r.wr = 1'b1; r.is_mem = 1'b1; r.rval = mword;
        end
        // Store merges: bits that fall beyond the word are dropped.
        mse_pkg::OP_SB: begin
          r.mw = 1'b1; r.is_mem = 1'b1;
          r.mval = mword ^ (((lane & 32'h0000_00FF) ^ (vt & 32'h0000_00FF)) << off);
        end
        mse_pkg::OP_SH: begin
          r.mw = 1'b1; r.is_mem = 1'b1;
          r.mval = mword ^ (((lane & 32'h0000_FFFF) ^ (vt & 32'h0000_FFFF)) << off);
        end
        mse_pkg::OP_SW: begin
          r.mw = 1'b1; r.is_mem = 1'b1; r.mval = vt;
        end
        default: r.ok = 1'b0;
      endcase
    end
    // Writes to register zero are dropped.
    if (!r.wr || r.ridx == 5'd0) begin
      r.wr   = 1'b0;
      r.ridx = 5'd0;
      r.rval = 32'd0;
    end
    res = r;
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// MIPS subset executor testbench
// Feeds instruction words to the executor core and checks every executed
// word against a cycle-free model of the processor state: register file,
// HI/LO, data memory, program counter and the pending delay-slot branch.
// Directed words cover the corner cases, then biased random programs run
// under three idling patterns with a different start address each time.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MEM_WORDS  = 4096;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_LEN  = 500;

  // One executed word as reported by the core.
  typedef struct {
    logic [31:0] exec_pc;
    logic        reg_we;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_we;
    logic [13:0] mem_byte_addr;
    logic [31:0] mem_value;
    logic [31:0] next_pc;
    logic        illegal;
  } retire_t;

  // Architectural model of the processor and the queue of expected words.
  class retire_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] hi, lo, pc, slot_pc;
    logic        slot_busy;
    retire_t     awaited [$];
    int          errors;

    function new();
      foreach (regs[k]) regs[k] = '0;
      foreach (dmem[k]) dmem[k] = '0;
      hi = '0;
      lo = '0;
      pc = mse_pkg::RESET_PC;
      slot_pc = '0;
      slot_busy = 1'b0;
      errors = 0;
    endfunction

    function void load_start(logic [31:0] addr);
      pc = addr;
      slot_busy = 1'b0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Executes one accepted word on the model and queues its outcome.
    function void note_word(logic [31:0] w);
      logic [5:0]  op, fn;
      logic [4:0]  si, ti, di, sh, ridx;
      logic [31:0] imm, simm, vs, vt, ea, mword, seq, br, jt;
      logic [31:0] rval, mval, tgt, nxt, nhi, nlo;
      logic [11:0] widx;
      logic [63:0] prod;
      longint      sa, sb_;
      int          off;
      logic        ok, wr, mw, xfer;
      retire_t     r;
      op = w[31:26];
      fn = w[5:0];
      si = w[25:21];
      ti = w[20:16];
      di = w[15:11];
      sh = w[10:6];
      imm = {16'h0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      vs = regs[si];
      vt = regs[ti];
      ea = vs + simm;
      widx = ea[13:2];
      off = ea[1:0] * 8;
      mword = dmem[widx];
      seq = pc + 32'd4;
      br = seq + (simm << 2);
      jt = {seq[31:28], w[25:0], 2'b00};
      ok = 1'b1;
      wr = 1'b0;
      mw = 1'b0;
      xfer = 1'b0;
      ridx = '0;
      rval = '0;
      mval = '0;
      tgt = '0;
      nhi = hi;
      nlo = lo;
      if (op == mse_pkg::OP_SPECIAL) begin
        wr = 1'b1;
        ridx = di;
        case (fn)
          mse_pkg::FN_ADD, mse_pkg::FN_ADDU: rval = vs + vt;
          mse_pkg::FN_SUB, mse_pkg::FN_SUBU: rval = vs - vt;
          mse_pkg::FN_AND:  rval = vs & vt;
          mse_pkg::FN_OR:   rval = vs | vt;
          mse_pkg::FN_XOR:  rval = vs ^ vt;
          mse_pkg::FN_NOR:  rval = ~(vs | vt);
          mse_pkg::FN_SLT:  rval = ($signed(vs) < $signed(vt)) ? 32'd1 : 32'd0;
          mse_pkg::FN_SLTU: rval = (vs < vt) ? 32'd1 : 32'd0;
          mse_pkg::FN_SLLV: rval = vt << vs[4:0];
          mse_pkg::FN_SRLV: rval = vt >> vs[4:0];
          mse_pkg::FN_SRAV: rval = $signed(vt) >>> vs[4:0];
          mse_pkg::FN_SLL:  rval = vt << sh;
          mse_pkg::FN_SRL:  rval = vt >> sh;
          mse_pkg::FN_SRA:  rval = $signed(vt) >>> sh;
          mse_pkg::FN_JR: begin
            wr = 1'b0;
            xfer = 1'b1;
            tgt = vs;
          end
          mse_pkg::FN_JALR: begin
            rval = pc + 32'd8;
            xfer = 1'b1;
            tgt = vs;
          end
          mse_pkg::FN_MFHI: rval = hi;
          mse_pkg::FN_MFLO: rval = lo;
          mse_pkg::FN_MTHI: begin
            wr = 1'b0;
            nhi = vs;
          end
          mse_pkg::FN_MTLO: begin
            wr = 1'b0;
            nlo = vs;
          end
          mse_pkg::FN_MULT, mse_pkg::FN_MULTU: begin
            wr = 1'b0;
            if (fn == mse_pkg::FN_MULT) begin
              sa = $signed(vs);
              sb_ = $signed(vt);
              prod = sa * sb_;
            end else begin
              prod = {32'h0, vs} * {32'h0, vt};
            end
            nhi = prod[63:32];
            nlo = prod[31:0];
          end
          mse_pkg::FN_DIV: begin
            wr = 1'b0;
            if (vt != '0) begin
              sa = $signed(vs);
              sb_ = $signed(vt);
              prod = sa / sb_;
              nlo = prod[31:0];
              prod = sa % sb_;
              nhi = prod[31:0];
            end
          end
          mse_pkg::FN_DIVU: begin
            wr = 1'b0;
            if (vt != '0) begin
              nlo = vs / vt;
              nhi = vs % vt;
            end
          end
          default: ok = 1'b0;
        endcase
      end else begin
        ridx = ti;
        case (op)
          mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin wr = 1'b1; rval = vs + simm; end
          mse_pkg::OP_ANDI: begin wr = 1'b1; rval = vs & imm; end
          mse_pkg::OP_ORI:  begin wr = 1'b1; rval = vs | imm; end
          mse_pkg::OP_XORI: begin wr = 1'b1; rval = vs ^ imm; end
          mse_pkg::OP_LUI:  begin wr = 1'b1; rval = imm << 16; end
          mse_pkg::OP_SLTI: begin
            wr = 1'b1;
            rval = ($signed(vs) < $signed(simm)) ? 32'd1 : 32'd0;
          end
          mse_pkg::OP_SLTIU: begin wr = 1'b1; rval = (vs < simm) ? 32'd1 : 32'd0; end
          mse_pkg::OP_BEQ:  begin xfer = (vs == vt); tgt = br; end
          mse_pkg::OP_BNE:  begin xfer = (vs != vt); tgt = br; end
          mse_pkg::OP_BGTZ: begin xfer = !vs[31] && vs != '0; tgt = br; end
          mse_pkg::OP_BLEZ: begin xfer = vs[31] || vs == '0; tgt = br; end
          mse_pkg::OP_REGIMM: begin
            if (ti == mse_pkg::RI_BGEZ) xfer = !vs[31];
            else if (ti == mse_pkg::RI_BLTZ) xfer = vs[31];
            else ok = 1'b0;
            tgt = br;
          end
          mse_pkg::OP_J: begin xfer = 1'b1; tgt = jt; end
          mse_pkg::OP_JAL: begin
            wr = 1'b1;
            ridx = mse_pkg::LINK_REG;
            rval = pc + 32'd8;
            xfer = 1'b1;
            tgt = jt;
          end
          mse_pkg::OP_LB: begin
            wr = 1'b1;
            rval = (mword >> off) & 32'hFF;
            if (rval[7]) rval |= 32'hFFFF_FF00;
          end
          mse_pkg::OP_LBU: begin wr = 1'b1; rval = (mword >> off) & 32'hFF; end
          mse_pkg::OP_LH: begin
            wr = 1'b1;
            rval = (mword >> off) & 32'hFFFF;
            if (rval[15]) rval |= 32'hFFFF_0000;
          end
          mse_pkg::OP_LHU: begin wr = 1'b1; rval = (mword >> off) & 32'hFFFF; end
          mse_pkg::OP_LW: begin wr = 1'b1; rval = mword; end
          mse_pkg::OP_SB: begin
            mw = 1'b1;
            mval = mword ^ ((((mword >> off) & 32'hFF) ^ (vt & 32'hFF)) << off);
          end
          mse_pkg::OP_SH: begin
            mw = 1'b1;
            mval = mword ^ ((((mword >> off) & 32'hFFFF) ^ (vt & 32'hFFFF)) << off);
          end
          mse_pkg::OP_SW: begin mw = 1'b1; mval = vt; end
          default: ok = 1'b0;
        endcase
      end
      r.exec_pc = pc;
      r.illegal = !ok;
      if (!ok) begin
        // An unknown encoding changes nothing and repeats the fetch address.
        r.reg_we = 1'b0;
        r.reg_index = '0;
        r.reg_value = '0;
        r.mem_we = 1'b0;
        r.mem_byte_addr = '0;
        r.mem_value = '0;
        r.next_pc = pc;
      end else begin
        if (wr && ridx != '0) begin
          regs[ridx] = rval;
        end else begin
          wr = 1'b0;
          ridx = '0;
          rval = '0;
        end
        if (mw) dmem[widx] = mval;
        hi = nhi;
        lo = nlo;
        // A branch inside a delay slot links but does not redirect.
        if (slot_busy) begin
          nxt = slot_pc;
          slot_busy = 1'b0;
        end else begin
          nxt = seq;
          if (xfer) begin
            slot_busy = 1'b1;
            slot_pc = tgt;
          end
        end
        pc = nxt;
        r.reg_we = wr;
        r.reg_index = ridx;
        r.reg_value = rval;
        r.mem_we = mw;
        r.mem_byte_addr = mw ? {widx, 2'b00} : '0;
        r.mem_value = mw ? mval : '0;
        r.next_pc = nxt;
      end
      awaited.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        errors++;
      end
    endfunction

    // Checks one retired word against the oldest expectation.
    function void check_word(retire_t got);
      retire_t want;
      if (awaited.size() == 0) begin
        $error("retired word at pc 0x%08h with nothing outstanding", got.exec_pc);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("exec_pc", want.exec_pc, got.exec_pc);
      compare("reg_we", want.reg_we, got.reg_we);
      compare("reg_index", want.reg_index, got.reg_index);
      compare("reg_value", want.reg_value, got.reg_value);
      compare("mem_we", want.mem_we, got.mem_we);
      compare("mem_byte_addr", want.mem_byte_addr, got.mem_byte_addr);
      compare("mem_value", want.mem_value, got.mem_value);
      compare("next_pc", want.next_pc, got.next_pc);
      compare("illegal", want.illegal, got.illegal);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_start_pc;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instr_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_exec_pc;
  logic        out_reg_we;
  logic [4:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_mem_we;
  logic [13:0] out_mem_byte_addr;
  logic [31:0] out_mem_value;
  logic [31:0] out_next_pc;
  logic        out_illegal;

  retire_scoreboard sb = new();
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int cycles;
  retire_t seen;

  mips_subset_instruction_executor_core #(.DATA_WORDS(MEM_WORDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_start_pc(cfg_start_pc),
    .in_valid(in_valid), .in_stall(in_stall), .in_instr_word(in_instr_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_exec_pc(out_exec_pc),
    .out_reg_we(out_reg_we), .out_reg_index(out_reg_index),
    .out_reg_value(out_reg_value), .out_mem_we(out_mem_we),
    .out_mem_byte_addr(out_mem_byte_addr), .out_mem_value(out_mem_value),
    .out_next_pc(out_next_pc), .out_illegal(out_illegal)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle cap on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[mips_subset_instruction_executor_core] ERROR");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off while one is counting down.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Sample every handshake at the rising edge.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.load_start(cfg_start_pc);
    if (rst_n && in_valid && !in_stall) sb.note_word(in_instr_word);
    if (rst_n && out_valid && !out_stall) begin
      seen.exec_pc = out_exec_pc;
      seen.reg_we = out_reg_we;
      seen.reg_index = out_reg_index;
      seen.reg_value = out_reg_value;
      seen.mem_we = out_mem_we;
      seen.mem_byte_addr = out_mem_byte_addr;
      seen.mem_value = out_mem_value;
      seen.next_pc = out_next_pc;
      seen.illegal = out_illegal;
      sb.check_word(seen);
    end
  end

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {mse_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Biased random instruction: mostly legal, with half of the memory accesses
  // kept in a small window so that stores are read back.
  function automatic logic [31:0] random_word();
    logic [5:0] fns [26] = '{mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_SRA,
                             mse_pkg::FN_SLLV, mse_pkg::FN_SRLV, mse_pkg::FN_SRAV,
                             mse_pkg::FN_JR, mse_pkg::FN_JALR, mse_pkg::FN_MFHI,
                             mse_pkg::FN_MTHI, mse_pkg::FN_MFLO, mse_pkg::FN_MTLO,
                             mse_pkg::FN_MULT, mse_pkg::FN_MULTU, mse_pkg::FN_DIV,
                             mse_pkg::FN_DIVU, mse_pkg::FN_ADD, mse_pkg::FN_ADDU,
                             mse_pkg::FN_SUB, mse_pkg::FN_SUBU, mse_pkg::FN_AND,
                             mse_pkg::FN_OR, mse_pkg::FN_XOR, mse_pkg::FN_NOR,
                             mse_pkg::FN_SLT, mse_pkg::FN_SLTU};
    logic [5:0] alu_ops [8] = '{mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_SLTI,
                                mse_pkg::OP_SLTIU, mse_pkg::OP_ANDI, mse_pkg::OP_ORI,
                                mse_pkg::OP_XORI, mse_pkg::OP_LUI};
    logic [5:0] mem_ops [8] = '{mse_pkg::OP_LB, mse_pkg::OP_LH, mse_pkg::OP_LW,
                                mse_pkg::OP_LBU, mse_pkg::OP_LHU, mse_pkg::OP_SB,
                                mse_pkg::OP_SH, mse_pkg::OP_SW};
    logic [5:0] br_ops [6] = '{mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_BLEZ,
                               mse_pkg::OP_BGTZ, mse_pkg::OP_J, mse_pkg::OP_JAL};
    logic [4:0] rs, rt;
    logic [15:0] imm;
    rs = 5'($urandom_range(0, 31));
    rt = 5'($urandom_range(0, 31));
    imm = 16'($urandom());
    case ($urandom_range(0, 19))
      0: return $urandom();
      1, 2, 3, 4, 5, 6:
        return rtype(fns[$urandom_range(0, 25)], rs, rt, 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)));
      7, 8, 9, 10, 11: return itype(alu_ops[$urandom_range(0, 7)], rs, rt, imm);
      12, 13, 14, 15: begin
        if ($urandom_range(0, 1)) begin
          rs = '0;
          imm = 16'($urandom_range(0, 63));
        end
        return itype(mem_ops[$urandom_range(0, 7)], rs, rt, imm);
      end
      16: begin
        rt = ($urandom_range(0, 7) == 0) ? rt : {4'b0, rt[0]};
        return itype(mse_pkg::OP_REGIMM, rs, rt, imm);
      end
      default: return {br_ops[$urandom_range(0, 5)], rs, rt, imm};
    endcase
  endfunction

  // Offers one word, with an optional idle gap first, and waits for it to go.
  task automatic send_word(logic [31:0] w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_instr_word <= w;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Restarts fetching at a new address once the core has gone quiet.
  task automatic set_start(logic [31:0] addr);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_start_pc <= addr;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < PHASE_LEN; n++) begin
      if (n == PHASE_LEN / 2 && idle < stall) hold_left = 400;
      if (n == PHASE_LEN / 2 && idle > stall) drain();
      send_word(random_word());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_start_pc = '0;
    in_valid = 1'b0;
    in_instr_word = '0;
    out_stall = 1'b0;
    hold_left = 0;
    cycles = 0;
    send_idle_pct = 13;
    stall_pct = 60;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corner cases on the reset start address.
    send_word(itype(mse_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
    send_word(itype(mse_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF));
    send_word(itype(mse_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
    send_word(itype(mse_pkg::OP_ADDI, 5'd0, 5'd3, 16'h7FFF));
    send_word(rtype(mse_pkg::FN_ADD, 5'd1, 5'd1, 5'd4, 5'd0));
    send_word(rtype(mse_pkg::FN_SUB, 5'd1, 5'd2, 5'd5, 5'd0));
    send_word(rtype(mse_pkg::FN_SLT, 5'd1, 5'd3, 5'd6, 5'd0));
    send_word(rtype(mse_pkg::FN_SLTU, 5'd1, 5'd3, 5'd6, 5'd0));
    send_word(rtype(mse_pkg::FN_SRAV, 5'd2, 5'd1, 5'd7, 5'd0));
    send_word(rtype(mse_pkg::FN_SLL, 5'd0, 5'd2, 5'd7, 5'd31));
    send_word(rtype(mse_pkg::FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0));
    send_word(rtype(mse_pkg::FN_MFHI, 5'd0, 5'd0, 5'd8, 5'd0));
    // Division by zero leaves HI and LO alone; most-negative by minus one.
    send_word(rtype(mse_pkg::FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0));
    send_word(itype(mse_pkg::OP_LUI, 5'd0, 5'd9, 16'h8000));
    send_word(rtype(mse_pkg::FN_DIV, 5'd9, 5'd2, 5'd0, 5'd0));
    send_word(rtype(mse_pkg::FN_MFLO, 5'd0, 5'd0, 5'd10, 5'd0));
    send_word(rtype(mse_pkg::FN_MTHI, 5'd3, 5'd0, 5'd0, 5'd0));
    // Misaligned half at the top byte lane, then read back.
    send_word(itype(mse_pkg::OP_SW, 5'd0, 5'd1, 16'd3));
    send_word(itype(mse_pkg::OP_SH, 5'd0, 5'd2, 16'd3));
    send_word(itype(mse_pkg::OP_LH, 5'd0, 5'd11, 16'd3));
    send_word(itype(mse_pkg::OP_LB, 5'd0, 5'd11, 16'd2));
    send_word(itype(mse_pkg::OP_LHU, 5'd0, 5'd11, 16'd1));
    // Taken branch with a jump-and-link in its delay slot.
    send_word(itype(mse_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFF0));
    send_word({mse_pkg::OP_JAL, 26'h3FF_FFFF});
    // Jump-and-link-register with the same source and destination.
    send_word(rtype(mse_pkg::FN_JALR, 5'd3, 5'd0, 5'd3, 5'd0));
    send_word(itype(mse_pkg::OP_ADDIU, 5'd0, 5'd0, 16'd5));
    send_word(itype(mse_pkg::OP_ADDIU, 5'd0, 5'd12, 16'd1));
    send_word(32'hFFFF_FFFF);

    set_start(32'h0000_0000);
    random_phase(13, 60);
    set_start(32'hFFFF_FFFF);
    random_phase(60, 13);
    set_start($urandom());
    random_phase(0, 0);

    drain();
    if (sb.errors == 0) begin
      $display("[mips_subset_instruction_executor_core] OK");
    end else begin
      $display("[mips_subset_instruction_executor_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mse_pkg.sv
hdl/mse_mdu.sv
hdl/mse_exec.sv
hdl/mips_subset_instruction_executor_core.sv
sim/testbench.sv
